// File: design/hmlm_pkg.sv
// Shared constants, types and helpers for the haptic motor level mapper.
// Used by the divider, exponent, lane and top-level modules.
package hmlm_pkg;

   // Pipeline depths of the iterative units
   localparam int DIV_STEPS  = 17;
   localparam int LOG_ROUNDS = 16;
   localparam int EXP_ROUNDS = 16;
   localparam int SQRT_STEPS = 31;
   localparam int EXP_STAGES = EXP_ROUNDS * SQRT_STEPS;
   localparam int UNITS      = 3;

   // Fixed-point limits
   localparam logic [15:0] THRESH_MAX = 16'd62259;
   localparam logic [15:0] CURVE_MIN  = 16'd82;
   localparam logic [15:0] CURVE_MAX  = 16'd32768;
   localparam logic [16:0] ONE_Q16    = 17'd65536;
   localparam logic [30:0] ONE_Q30    = 31'h4000_0000;
   localparam logic [15:0] LEVEL_MAX  = 16'hFFFF;

   // Register indexes of the configuration port
   typedef enum logic [2:0] {
      CSR_FLOORS   = 3'd0,
      CSR_ENERGY_W = 3'd1,
      CSR_PEAK_W   = 3'd2,
      CSR_TRANS_W  = 3'd3,
      CSR_THRESH   = 3'd4,
      CSR_CURVE    = 3'd5,
      CSR_GAIN     = 3'd6
   } csr_index_type;

   // Control bits that travel beside the payload of every stage
   typedef struct packed {
      logic valid;
      logic kill;
   } side_type;

endpackage

// File: design/hmlm_div.sv
// Pipelined restoring divider: quo = num * 65536 / den for num <= den.
// One quotient bit per stage; depends on hmlm_pkg.
module hmlm_div import hmlm_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        en,
   input  side_type    in_side,
   input  logic [16:0] num,
   input  logic [16:0] den,
   output side_type    out_side,
   output logic [16:0] quo
);

   logic [16:0] rem_ff  [DIV_STEPS];
   logic [16:0] den_ff  [DIV_STEPS];
   logic [16:0] quo_ff  [DIV_STEPS];
   side_type    side_ff [DIV_STEPS];

   genvar i;
   for (i = 0; i < DIV_STEPS; i++) begin : g_step
      logic [17:0] rem_cur;
      logic [16:0] den_cur;
      logic [16:0] quo_cur;
      side_type    side_cur;
      logic        ge;

      if (i == 0) begin : g_first
         assign rem_cur  = {1'b0, num};
         assign den_cur  = den;
         assign quo_cur  = '0;
         assign side_cur = in_side;
      end else begin : g_next
         assign rem_cur  = {rem_ff[i-1], 1'b0};
         assign den_cur  = den_ff[i-1];
         assign quo_cur  = quo_ff[i-1];
         assign side_cur = side_ff[i-1];
      end

      // compare and subtract one quotient bit
      assign ge = rem_cur >= {1'b0, den_cur};

      always_ff @(posedge clock) begin
         if (reset) begin
            side_ff[i] <= '0;
         end else if (en) begin
            side_ff[i] <= side_cur;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[i] <= ge ? 17'(rem_cur - {1'b0, den_cur}) : rem_cur[16:0];
            den_ff[i] <= den_cur;
            quo_ff[i] <= {quo_cur[15:0], ge};
         end
      end
   end

   assign quo      = quo_ff[DIV_STEPS-1];
   assign out_side = side_ff[DIV_STEPS-1];

endmodule

// File: design/hmlm_exp.sv
// Pipelined 2^(-p/65536) in Q1.30 by repeated floor square roots.
// Each root takes one result bit per stage; depends on hmlm_pkg.
module hmlm_exp import hmlm_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        en,
   input  side_type    in_side,
   input  logic [23:0] pwr,
   output side_type    out_side,
   output logic [30:0] y
);

   logic [60:0] rem_ff  [EXP_STAGES];
   logic [30:0] root_ff [EXP_STAGES];
   logic [15:0] frac_ff [EXP_STAGES];
   logic [7:0]  sh_ff   [EXP_STAGES];
   side_type    side_ff [EXP_STAGES];
   logic [30:0] y_ff;
   side_type    y_side_ff;

   genvar j, s;
   for (j = 0; j < EXP_ROUNDS; j++) begin : g_round
      for (s = 0; s < SQRT_STEPS; s++) begin : g_bit
         localparam int IDX = j * SQRT_STEPS + s;
         localparam int B   = SQRT_STEPS - 1 - s;
         logic [60:0] rem_cur;
         logic [30:0] root_cur;
         logic [15:0] frac_cur;
         logic [7:0]  sh_cur;
         side_type    side_cur;
         logic [63:0] trial;
         logic        take;

         if (s == 0) begin : g_load
            logic [30:0] y_prev;
            logic [30:0] t_val;
            if (j == 0) begin : g_seed
               assign y_prev   = ONE_Q30;
               assign frac_cur = pwr[15:0];
               assign sh_cur   = pwr[23:16];
               assign side_cur = in_side;
            end else begin : g_chain
               assign y_prev   = root_ff[IDX-1];
               assign frac_cur = frac_ff[IDX-1];
               assign sh_cur   = sh_ff[IDX-1];
               assign side_cur = side_ff[IDX-1];
            end
            // halve on a set fraction bit, then take the root of t << 30
            assign t_val    = frac_cur[j] ? (y_prev >> 1) : y_prev;
            assign rem_cur  = {t_val[30:0], 30'b0};
            assign root_cur = '0;
         end else begin : g_mid
            assign rem_cur  = rem_ff[IDX-1];
            assign root_cur = root_ff[IDX-1];
            assign frac_cur = frac_ff[IDX-1];
            assign sh_cur   = sh_ff[IDX-1];
            assign side_cur = side_ff[IDX-1];
         end

         // (root + 2^B)^2 - root^2
         assign trial = ({33'b0, root_cur} << (B + 1)) + (64'd1 << (2 * B));
         assign take  = trial <= {3'b0, rem_cur};

         always_ff @(posedge clock) begin
            if (reset) begin
               side_ff[IDX] <= '0;
            end else if (en) begin
               side_ff[IDX] <= side_cur;
            end
         end

         always_ff @(posedge clock) begin
            if (en) begin
               rem_ff[IDX]  <= take ? 61'({3'b0, rem_cur} - trial) : rem_cur;
               root_ff[IDX] <= take ? (root_cur | (31'd1 << B)) : root_cur;
               frac_ff[IDX] <= frac_cur;
               sh_ff[IDX]   <= sh_cur;
            end
         end
      end
   end

   // Apply the integer part of the exponent as a right shift
   always_ff @(posedge clock) begin
      if (reset) begin
         y_side_ff <= '0;
      end else if (en) begin
         y_side_ff <= side_ff[EXP_STAGES-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         y_ff <= (sh_ff[EXP_STAGES-1] >= 8'd31) ? '0
               : (root_ff[EXP_STAGES-1] >> sh_ff[EXP_STAGES-1]);
      end
   end

   assign y        = y_ff;
   assign out_side = y_side_ff;

endmodule

// File: design/hmlm_lane.sv
// One channel of the mapper: normalize, weight, gate, curve and gain.
// Depends on hmlm_pkg, hmlm_div and hmlm_exp.
module hmlm_lane import hmlm_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        en,
   input  logic        in_valid,
   input  logic        active,
   input  logic [15:0] energy,
   input  logic [15:0] peak,
   input  logic [15:0] transient,
   input  logic [47:0] floors,
   input  logic [15:0] energy_weight,
   input  logic [15:0] peak_weight,
   input  logic [15:0] transient_weight,
   input  logic [15:0] threshold,
   input  logic [15:0] curve,
   input  logic [16:0] gain,
   output logic        out_valid,
   output logic [7:0]  level
);

   logic [15:0] lvl_in  [UNITS];
   logic [15:0] weight  [UNITS];
   logic [16:0] num_ff  [UNITS];
   logic [16:0] den_ff  [UNITS];
   logic [16:0] unit_q  [UNITS];
   side_type    unit_side [UNITS];
   logic [32:0] prod_ff [UNITS];
   side_type    prep_side_ff, prod_side_ff, sum_side_ff, gate_side_ff;
   side_type    div_side, g_side, k_side_ff, nl_side_ff, p_side_ff;
   side_type    e_side, yg_side_ff;
   side_type    log_side_ff [LOG_ROUNDS];
   logic [30:0] x_ff    [LOG_ROUNDS];
   logic [15:0] frac_ff [LOG_ROUNDS];
   logic [4:0]  klog_ff [LOG_ROUNDS];
   logic [34:0] sum;
   logic [16:0] c_ff, n2_ff, d2_ff, g_q, g1;
   logic [15:0] thr, cv;
   logic [16:0] gn;
   logic        gate;
   logic [4:0]  k, k_ff;
   logic [30:0] m_ff;
   logic [20:0] nl_ff;
   logic [36:0] pr;
   logic [23:0] p_ff;
   logic [30:0] y_e;
   logic [47:0] yg_ff;
   logic [55:0] sc;
   logic [9:0]  lvl;
   logic [7:0]  level_ff;

   assign lvl_in[0] = energy;
   assign lvl_in[1] = peak;
   assign lvl_in[2] = transient;
   assign weight[0] = energy_weight;
   assign weight[1] = peak_weight;
   assign weight[2] = transient_weight;

   // Clamp threshold, curve and gain
   assign thr = (threshold > THRESH_MAX) ? THRESH_MAX : threshold;
   assign cv  = (curve < CURVE_MIN) ? CURVE_MIN : ((curve > CURVE_MAX) ? CURVE_MAX : curve);
   assign gn  = (gain > ONE_Q16) ? ONE_Q16 : gain;

   // Floor each level and normalize it to Q1.16 through a divider
   genvar i;
   for (i = 0; i < UNITS; i++) begin : g_unit
      logic [15:0] fl;
      logic        zero;
      assign fl   = floors[16*i +: 16];
      assign zero = lvl_in[i] <= fl;

      always_ff @(posedge clock) begin
         if (en) begin
            num_ff[i] <= zero ? 17'd0 : {1'b0, 16'(lvl_in[i] - fl)};
            den_ff[i] <= zero ? 17'd1 : {1'b0, 16'(LEVEL_MAX - fl)};
         end
      end

      hmlm_div u_div (
         .clock    (clock),
         .reset    (reset),
         .en       (en),
         .in_side  (prep_side_ff),
         .num      (num_ff[i]),
         .den      (den_ff[i]),
         .out_side (unit_side[i]),
         .quo      (unit_q[i])
      );

      always_ff @(posedge clock) begin
         if (en) begin
            prod_ff[i] <= {16'b0, unit_q[i]} * {17'b0, weight[i]};
         end
      end
   end

   assign div_side.valid = unit_side[0].valid & unit_side[1].valid & unit_side[2].valid;
   assign div_side.kill  = unit_side[0].kill | unit_side[1].kill | unit_side[2].kill;

   // Sum the weighted units and saturate at 1.0
   assign sum = {2'b0, prod_ff[0]} + {2'b0, prod_ff[1]} + {2'b0, prod_ff[2]};

   // Gate against the threshold
   assign gate = c_ff <= {1'b0, thr};

   hmlm_div u_gdiv (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_side  (gate_side_ff),
      .num      (n2_ff),
      .den      (d2_ff),
      .out_side (g_side),
      .quo      (g_q)
   );

   // Normalize g to Q1.30 by its top set bit
   assign g1 = (g_q == '0) ? 17'd1 : g_q;
   always_comb begin
      k = '0;
      for (int b = 1; b < 17; b++) begin
         if (g1[b]) begin
            k = 5'(b);
         end
      end
   end

   // Fraction bits of log2 by repeated squaring
   genvar r;
   for (r = 0; r < LOG_ROUNDS; r++) begin : g_log
      logic [30:0] x_cur;
      logic [15:0] f_cur;
      logic [4:0]  k_cur;
      side_type    s_cur;
      logic [61:0] sq;
      logic [31:0] xx;

      if (r == 0) begin : g_first
         assign x_cur = m_ff;
         assign f_cur = '0;
         assign k_cur = k_ff;
         assign s_cur = k_side_ff;
      end else begin : g_next
         assign x_cur = x_ff[r-1];
         assign f_cur = frac_ff[r-1];
         assign k_cur = klog_ff[r-1];
         assign s_cur = log_side_ff[r-1];
      end

      assign sq = {31'b0, x_cur} * {31'b0, x_cur};
      assign xx = sq[61:30];

      always_ff @(posedge clock) begin
         if (reset) begin
            log_side_ff[r] <= '0;
         end else if (en) begin
            log_side_ff[r] <= s_cur;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            x_ff[r]    <= xx[31] ? xx[31:1] : xx[30:0];
            frac_ff[r] <= {f_cur[14:0], xx[31]};
            klog_ff[r] <= k_cur;
         end
      end
   end

   // Scale -log2(g) by the curve exponent
   assign pr = {16'b0, nl_ff} * {21'b0, cv};

   hmlm_exp u_exp (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_side  (p_side_ff),
      .pwr      (p_ff),
      .out_side (e_side),
      .y        (y_e)
   );

   // Gain, times 255, round and saturate
   assign sc  = ({8'b0, yg_ff} << 8) - {8'b0, yg_ff} + (56'd1 << 45);
   assign lvl = sc[55:46];

   // Control stage registers
   always_ff @(posedge clock) begin
      if (reset) begin
         prep_side_ff <= '0;
         prod_side_ff <= '0;
         sum_side_ff  <= '0;
         gate_side_ff <= '0;
         k_side_ff    <= '0;
         nl_side_ff   <= '0;
         p_side_ff    <= '0;
         yg_side_ff   <= '0;
      end else if (en) begin
         prep_side_ff       <= '{valid: in_valid, kill: !active};
         prod_side_ff       <= div_side;
         sum_side_ff        <= prod_side_ff;
         gate_side_ff.valid <= sum_side_ff.valid;
         gate_side_ff.kill  <= sum_side_ff.kill | gate;
         k_side_ff          <= g_side;
         nl_side_ff         <= log_side_ff[LOG_ROUNDS-1];
         p_side_ff          <= nl_side_ff;
         yg_side_ff         <= e_side;
      end
   end

   // Payload stage registers
   always_ff @(posedge clock) begin
      if (en) begin
         c_ff     <= (sum > 35'(ONE_Q30)) ? ONE_Q16 : sum[30:14];
         n2_ff    <= gate ? 17'd0 : 17'(c_ff - {1'b0, thr});
         d2_ff    <= 17'(ONE_Q16 - {1'b0, thr});
         k_ff     <= k;
         m_ff     <= 31'(g1) << (5'd30 - k);
         nl_ff    <= {5'(5'd16 - klog_ff[LOG_ROUNDS-1]), 16'b0}
                   - {5'b0, frac_ff[LOG_ROUNDS-1]};
         p_ff     <= pr[36:13];
         yg_ff    <= {17'b0, y_e} * {31'b0, gn};
         level_ff <= yg_side_ff.kill ? 8'd0 : ((lvl > 10'd255) ? 8'd255 : lvl[7:0]);
      end
   end

   // Output stage valid
   logic out_valid_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (en) begin
         out_valid_ff <= yg_side_ff.valid;
      end
   end

   assign out_valid = out_valid_ff;
   assign level     = level_ff;

endmodule

// File: design/haptic_motor_level_mapper.sv
// Top level of the haptic motor level mapper: configuration registers,
// two channel lanes and the merging output register. Depends on hmlm_pkg, hmlm_lane.
//
//   channel  direction  handshake              payload
//   req_     in         req_tvalid/req_tready  tdata: six 16-bit levels, tuser: audio flag
//   rsp_     out        rsp_tvalid/rsp_tready  tdata: left_motor, right_motor
//   csr_     in         csr_valid/csr_ready    csr_index, csr_data
//
// One report is accepted per cycle while the output is not stalled. Each lane has 556
// register stages, most of them in the 16 square roots of the exponent unit at one
// result bit per stage; they and the output register lie between a request
// transaction and its result on rsp_. Reset clears the valid bits and loads the
// register defaults. When a result waits at rsp_ and rsp_tready is low, the whole
// pipeline holds and req_tready drops.
module haptic_motor_level_mapper import hmlm_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [95:0] req_tdata,  // left_energy, left_peak, left_transient,
                                   // right_energy, right_peak, right_transient
   input  logic        req_tuser,  // is_audio_haptics
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,  // left_motor, right_motor
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [47:0] csr_data
);

   logic [47:0] floors_ff;
   logic [15:0] energy_w_ff, peak_w_ff, trans_w_ff, thresh_ff, curve_ff;
   logic [16:0] gain_ff;
   logic        en;
   logic        left_valid, right_valid;
   logic [7:0]  left_level, right_level;
   logic        rsp_valid_ff;
   logic [15:0] rsp_data_ff;

   // Configuration writes are always taken
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         floors_ff   <= '0;
         energy_w_ff <= 16'd16384;
         peak_w_ff   <= '0;
         trans_w_ff  <= '0;
         thresh_ff   <= '0;
         curve_ff    <= 16'd8192;
         gain_ff     <= ONE_Q16;
      end else if (csr_valid) begin
         case (csr_index_type'(csr_index))
            CSR_FLOORS:   floors_ff   <= csr_data;
            CSR_ENERGY_W: energy_w_ff <= csr_data[15:0];
            CSR_PEAK_W:   peak_w_ff   <= csr_data[15:0];
            CSR_TRANS_W:  trans_w_ff  <= csr_data[15:0];
            CSR_THRESH:   thresh_ff   <= csr_data[15:0];
            CSR_CURVE:    curve_ff    <= csr_data[15:0];
            CSR_GAIN:     gain_ff     <= csr_data[16:0];
            default: ;
         endcase
      end
   end

   // Advance the pipeline unless a result is stalled at the output
   assign en         = !rsp_valid_ff || rsp_tready;
   assign req_tready = en;

   hmlm_lane u_left (
      .clock            (clock),
      .reset            (reset),
      .en               (en),
      .in_valid         (req_tvalid),
      .active           (req_tuser),
      .energy           (req_tdata[15:0]),
      .peak             (req_tdata[31:16]),
      .transient        (req_tdata[47:32]),
      .floors           (floors_ff),
      .energy_weight    (energy_w_ff),
      .peak_weight      (peak_w_ff),
      .transient_weight (trans_w_ff),
      .threshold        (thresh_ff),
      .curve            (curve_ff),
      .gain             (gain_ff),
      .out_valid        (left_valid),
      .level            (left_level)
   );

   hmlm_lane u_right (
      .clock            (clock),
      .reset            (reset),
      .en               (en),
      .in_valid         (req_tvalid),
      .active           (req_tuser),
      .energy           (req_tdata[63:48]),
      .peak             (req_tdata[79:64]),
      .transient        (req_tdata[95:80]),
      .floors           (floors_ff),
      .energy_weight    (energy_w_ff),
      .peak_weight      (peak_w_ff),
      .transient_weight (trans_w_ff),
      .threshold        (thresh_ff),
      .curve            (curve_ff),
      .gain             (gain_ff),
      .out_valid        (right_valid),
      .level            (right_level)
   );

   // Merge both lanes into the output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= left_valid & right_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_data_ff <= {right_level, left_level};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

// File: tb/haptic_motor_level_mapper_tb.sv
// Testbench for the haptic motor level mapper: directed and random reports
// checked against a bit-exact integer predictor. Depends on hmlm_pkg and the top level.
module haptic_motor_level_mapper_tb;
   import hmlm_pkg::*;

   typedef struct packed {
      logic        audio;
      logic [15:0] l_en, l_pk, l_tr, r_en, r_pk, r_tr;
   } report_type;

   // left_motor sits in the low byte of rsp_tdata
   typedef struct packed {
      logic [7:0] right_lvl, left_lvl;
   } motor_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [95:0] req_tdata = '0;
   logic        req_tuser = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [2:0]  csr_index = '0;
   logic [47:0] csr_data = '0;

   // configuration copy
   logic [47:0] floors_q;
   logic [15:0] w_en_q, w_pk_q, w_tr_q, thresh_q, curve_q;
   logic [16:0] gain_q;

   motor_type motor_expected[$];
   int     fail_count = 0;
   int     cycle_count = 0;
   bit     stall_enable = 1'b1;
   bit     hold_off = 1'b0;
   bit     gap_enable = 1'b1;

   localparam int LATENCY   = 600;
   localparam int CYCLE_CAP = 400000;

   haptic_motor_level_mapper u_dut (.*);

   always #4 clock = ~clock;

   // cycle limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_CAP) begin
         $display("tb: failure");
         $finish;
      end
   end

   function automatic logic [63:0] unit_q16(logic [15:0] v, logic [15:0] fl);
      if (v <= fl || fl == 16'hFFFF) return 64'd0;
      return ((64'(v) - fl) * 65536) / (64'hFFFF - fl);
   endfunction

   function automatic logic [63:0] floor_sqrt(logic [63:0] a);
      logic [63:0] r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > a) b = b >> 2;
      while (b != 0) begin
         if (a >= r + b) begin
            a = a - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   function automatic logic [7:0] channel_level(logic [15:0] en, logic [15:0] pk,
                                                logic [15:0] tr);
      logic [63:0] s, c, t, g, x, frac, nl, p, y, n, f, crv, gn, lvl;
      int k;
      s = unit_q16(en, floors_q[15:0]) * w_en_q + unit_q16(pk, floors_q[31:16]) * w_pk_q
        + unit_q16(tr, floors_q[47:32]) * w_tr_q;
      if (s > 64'd1 << 30) s = 64'd1 << 30;
      c = s >> 14;
      t = (thresh_q > THRESH_MAX) ? THRESH_MAX : thresh_q;
      if (c <= t) return 8'd0;
      g = ((c - t) * 65536) / (65536 - t);
      if (g == 0) g = 1;
      crv = (curve_q < CURVE_MIN) ? CURVE_MIN : (curve_q > CURVE_MAX) ? CURVE_MAX : curve_q;
      // log2 by repeated squaring
      k = 0;
      while (k < 16 && (g >> (k + 1)) != 0) k++;
      x = g << (30 - k);
      frac = 0;
      for (int i = 0; i < 16; i++) begin
         x = (x * x) >> 30;
         frac = frac << 1;
         if (x >= 64'd1 << 31) begin
            frac = frac | 1;
            x = x >> 1;
         end
      end
      nl = 16 * 65536 - (64'(k) * 65536 + frac);
      p = (nl * crv) >> 13;
      // exp2 by square roots
      n = p >> 16;
      f = p & 16'hFFFF;
      y = 64'd1 << 30;
      for (int i = 0; i < 16; i++)
         y = floor_sqrt((f[i] ? (y >> 1) : y) << 30);
      y = (n >= 31) ? 0 : (y >> n);
      gn = (gain_q > ONE_Q16) ? ONE_Q16 : gain_q;
      lvl = (y * gn * 255 + (64'd1 << 45)) >> 46;
      return (lvl > 255) ? 8'd255 : lvl[7:0];
   endfunction

   function automatic motor_type predict_motors(report_type r);
      motor_type m;
      m = '0;
      if (r.audio) begin
         m.left_lvl  = channel_level(r.l_en, r.l_pk, r.l_tr);
         m.right_lvl = channel_level(r.r_en, r.r_pk, r.r_tr);
      end
      return m;
   endfunction

   // drop valid for a random idle burst
   task automatic idle_gap();
      if (gap_enable && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(negedge clock);
      end
   endtask

   // send one report and queue its expected motor levels
   task automatic send_report(report_type r);
      idle_gap();
      req_tvalid <= 1'b1;
      req_tuser  <= r.audio;
      req_tdata  <= {r.r_tr, r.r_pk, r.r_en, r.l_tr, r.l_pk, r.l_en};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      motor_expected.push_back(predict_motors(r));
      @(negedge clock);
   endtask

   task automatic write_csr(csr_index_type idx, logic [47:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         CSR_FLOORS:   floors_q = val;
         CSR_ENERGY_W: w_en_q   = val[15:0];
         CSR_PEAK_W:   w_pk_q   = val[15:0];
         CSR_TRANS_W:  w_tr_q   = val[15:0];
         CSR_THRESH:   thresh_q = val[15:0];
         CSR_CURVE:    curve_q  = val[15:0];
         CSR_GAIN:     gain_q   = val[16:0];
         default: ;
      endcase
      @(negedge clock);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (motor_expected.size() != 0) @(negedge clock);
      repeat (LATENCY) @(negedge clock);
   endtask

   task automatic set_config(logic [47:0] fl, logic [15:0] we, logic [15:0] wp,
                             logic [15:0] wt, logic [15:0] th, logic [15:0] cv,
                             logic [16:0] gn);
      drain();
      write_csr(CSR_FLOORS, fl);
      write_csr(CSR_ENERGY_W, 48'(we));
      write_csr(CSR_PEAK_W, 48'(wp));
      write_csr(CSR_TRANS_W, 48'(wt));
      write_csr(CSR_THRESH, 48'(th));
      write_csr(CSR_CURVE, 48'(cv));
      write_csr(CSR_GAIN, 48'(gn));
      csr_valid <= 1'b0;
   endtask

   function automatic report_type random_report();
      report_type r;
      r = 97'({$urandom, $urandom, $urandom, $urandom});
      r.audio = ($urandom_range(0, 7) != 0);
      // bias some levels toward the extremes
      if ($urandom_range(0, 5) == 0) r.l_en = 16'hFFFF;
      if ($urandom_range(0, 5) == 0) r.r_pk = 16'h0000;
      return r;
   endfunction

   task automatic test_directed();
      report_type r;
      r = '0;
      r.audio = 1'b1;
      send_report(r);
      r = '1;
      send_report(r);
      r.audio = 1'b0;
      send_report(r);
      r = {1'b1, 16'h8000, 16'h4000, 16'h0001, 16'hFFFE, 16'h0100, 16'h7FFF};
      send_report(r);
      r = {1'b1, 16'h0001, 16'hFFFF, 16'hFFFF, 16'h0002, 16'hC000, 16'h1234};
      send_report(r);
      // all weights at full scale, but floors at all ones zero every unit
      set_config('1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000, 16'h2000, 17'h1FFFF);
      send_report('1);
      send_report({1'b1, {6{16'h8000}}});
      set_config(48'h0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 17'd0);
      send_report('1);
      send_report({1'b1, {6{16'hFFF0}}});
      set_config(48'h8000_4000_1000, 16'h4000, 16'h2000, 16'h1000, 16'h8000,
                 16'd0, 17'd65535);
      send_report('1);
      send_report({1'b1, {6{16'hC000}}});
      send_report({1'b1, {6{16'hE000}}});
      set_config(48'h0, 16'h4000, 16'h0, 16'h0, 16'h0, 16'd81, 17'd65536);
      send_report({1'b1, {6{16'h0001}}});
      send_report({1'b1, {6{16'h4000}}});
      set_config(48'h0, 16'h4000, 16'h0, 16'h0, 16'h0, 16'd32769, 17'd65536);
      send_report({1'b1, {6{16'h0001}}});
      send_report({1'b1, {6{16'hF000}}});
   endtask

   task automatic test_random(int count);
      for (int i = 0; i < count; i++) begin
         if (i % 20 == 0)
            set_config(48'({$urandom, $urandom}), 16'($urandom),
                       16'($urandom_range(0, 8000)), 16'($urandom_range(0, 8000)),
                       16'($urandom_range(0, 40000)), 16'($urandom_range(0, 40000)),
                       17'($urandom_range(0, 70000)));
         send_report(random_report());
      end
   endtask

   // hold the receiver off long enough for the pipeline to fill
   task automatic test_backpressure();
      drain();
      gap_enable = 1'b0;
      hold_off = 1'b1;
      fork
         begin
            repeat (1200) @(negedge clock);
            hold_off = 1'b0;
         end
         for (int i = 0; i < 600 && hold_off; i++) send_report(random_report());
      join
      gap_enable = 1'b1;
   endtask

   // receiver stalls
   always @(negedge clock) begin
      if (hold_off) begin
         rsp_tready <= 1'b0;
      end else if (stall_enable && $urandom_range(0, 5) == 0) begin
         rsp_tready <= 1'b0;
         repeat ($urandom_range(1, 7) - 1) @(negedge clock);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // check each result transaction
   always @(posedge clock) begin
      motor_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata;
         if (motor_expected.size() == 0) begin
            $display("%0t: unexpected result %h", $time, got);
            fail_count++;
         end else begin
            want = motor_expected.pop_front();
            if (got.left_lvl !== want.left_lvl)
               $display("%0t: left_motor expected %0d actual %0d", $time,
                        want.left_lvl, got.left_lvl);
            if (got.right_lvl !== want.right_lvl)
               $display("%0t: right_motor expected %0d actual %0d", $time,
                        want.right_lvl, got.right_lvl);
            if (got !== want) fail_count++;
         end
      end
   end

   initial begin
      floors_q = '0;
      w_en_q   = 16'd16384;
      w_pk_q   = '0;
      w_tr_q   = '0;
      thresh_q = '0;
      curve_q  = 16'd8192;
      gain_q   = 17'd65536;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_random(40);
      test_backpressure();
      // last stretch without idling
      drain();
      stall_enable = 1'b0;
      gap_enable = 1'b0;
      test_random(40);
      drain();
      if (fail_count == 0 && motor_expected.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

// File: haptic_motor_level_mapper.f
design/hmlm_pkg.sv
design/hmlm_div.sv
design/hmlm_exp.sv
design/hmlm_lane.sv
design/haptic_motor_level_mapper.sv
tb/haptic_motor_level_mapper_tb.sv
